// ===== rtl/sorting_deque_engine_macros.svh =====
// Assertion macros used by the deque engine's top level.
// Included by the top level; relies on i_clk and i_rst_n in the including scope.
`ifndef SORTING_DEQUE_ENGINE_MACROS_SVH
`define SORTING_DEQUE_ENGINE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sorting_deque_engine: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SDE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorting_deque_engine: next-cycle check failed");

`endif

// ===== rtl/sde_pkg.sv =====
// Shared types, constants and helpers for the sorting deque engine.
// No dependencies; the interfaces, controller, datapath and top level refer to it by scoped names.
package sde_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // Fixed field widths of the two channels.
    localparam int OP_W        = 3;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int OUT_COUNT_W = 5;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_SORT       = 3'd4;
    localparam logic [OP_W-1:0] OP_DEDUP      = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP,
        S_SORT_PRIME,
        S_SORT_LOAD,
        S_SORT_STEP,
        S_SORT_LAST,
        S_FINISH,
        S_DD_CRD,
        S_DD_CLD,
        S_DD_SCAN,
        S_DD_DONE
    } t_state;

    typedef enum logic [4:0] {
        A_NOP,
        A_PUSH_FRONT,
        A_PUSH_BACK,
        A_POP_FRONT,
        A_POP_BACK,
        A_POP_DONE,
        A_REPORT,
        A_SORT_INIT,
        A_SORT_PRIME,
        A_SORT_LOAD,
        A_SORT_STEP,
        A_SORT_LAST,
        A_DD_INIT,
        A_DD_CRD,
        A_DD_CLD,
        A_DD_SCAN,
        A_DD_DONE
    } t_act;

    typedef struct packed {
        t_act                act;
        logic [STATUS_W-1:0] status;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic few_entries;
        logic k_at_lim;
        logic lim_one;
        logic is_match;
        logic j_last;
        logic i_last;
    } t_dp_sts;

    // Ring position of an offset from the front entry; both are below CAPACITY.
    function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] front,
                                                  input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, front} + {1'b0, off};
        if (sum >= (IDX_W + 1)'(CAPACITY)) begin
            sum = sum - (IDX_W + 1)'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// ===== rtl/sde_in_if.sv =====
// Operation channel of the deque engine: valid/ready with op and value.
// Depends on sde_pkg for the field widths.
interface sde_in_if;
    logic                             valid;
    logic                             ready;
    logic [sde_pkg::OP_W-1:0]         op;
    logic signed [sde_pkg::VALUE_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

// ===== rtl/sde_out_if.sv =====
// Result channel of the deque engine: valid/ready with status, count, removed word.
// Depends on sde_pkg for the field widths.
interface sde_out_if;
    logic                                valid;
    logic                                ready;
    logic [sde_pkg::STATUS_W-1:0]        status;
    logic [sde_pkg::OUT_COUNT_W-1:0]     count;
    logic signed [sde_pkg::VALUE_W-1:0]  removed_value;

    modport source (output valid, output status, output count, output removed_value,
                    input ready);
    modport sink   (input valid, input status, input count, input removed_value,
                    output ready);
endinterface

// ===== rtl/sde_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module sde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sde_ctrl.sv =====
// Controller of the deque engine: state machine that sequences pushes, pops,
// the bubble sort passes and the dedup scan. Depends on sde_pkg.
module sde_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic [sde_pkg::OP_W-1:0] i_op,
    input  logic                     i_out_ready,
    input  sde_pkg::t_dp_sts         i_sts,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    output sde_pkg::t_dp_cmd         o_cmd
);

    sde_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            w_accept;
    logic            w_load;

    assign o_in_ready  = (r_state == sde_pkg::S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            sde_pkg::S_IDLE: begin
                if (w_accept) begin
                    case (i_op)
                        sde_pkg::OP_POP_FRONT, sde_pkg::OP_POP_BACK: begin
                            if (!i_sts.empty) n_state = sde_pkg::S_POP;
                        end
                        sde_pkg::OP_SORT: begin
                            if (!i_sts.few_entries) n_state = sde_pkg::S_SORT_LOAD;
                        end
                        sde_pkg::OP_DEDUP: begin
                            if (!i_sts.few_entries) n_state = sde_pkg::S_DD_CLD;
                        end
                        default: n_state = sde_pkg::S_IDLE;
                    endcase
                end
            end
            sde_pkg::S_POP:       n_state = sde_pkg::S_IDLE;
            sde_pkg::S_SORT_PRIME: n_state = sde_pkg::S_SORT_LOAD;
            sde_pkg::S_SORT_LOAD: n_state = sde_pkg::S_SORT_STEP;
            sde_pkg::S_SORT_STEP: begin
                if (i_sts.k_at_lim) n_state = sde_pkg::S_SORT_LAST;
            end
            sde_pkg::S_SORT_LAST: begin
                n_state = i_sts.lim_one ? sde_pkg::S_FINISH : sde_pkg::S_SORT_PRIME;
            end
            sde_pkg::S_FINISH:    n_state = sde_pkg::S_IDLE;
            sde_pkg::S_DD_CRD:    n_state = sde_pkg::S_DD_CLD;
            sde_pkg::S_DD_CLD:    n_state = sde_pkg::S_DD_SCAN;
            sde_pkg::S_DD_SCAN: begin
                if (i_sts.is_match || i_sts.j_last) begin
                    n_state = i_sts.i_last ? sde_pkg::S_DD_DONE : sde_pkg::S_DD_CRD;
                end
            end
            sde_pkg::S_DD_DONE:   n_state = sde_pkg::S_IDLE;
            default:              n_state = sde_pkg::S_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb begin
        o_cmd.act    = sde_pkg::A_NOP;
        o_cmd.status = sde_pkg::ST_OK;
        case (r_state)
            sde_pkg::S_IDLE: begin
                if (w_accept) begin
                    case (i_op)
                        sde_pkg::OP_PUSH_FRONT, sde_pkg::OP_PUSH_BACK: begin
                            if (i_sts.full) begin
                                o_cmd.act    = sde_pkg::A_REPORT;
                                o_cmd.status = sde_pkg::ST_FULL;
                            end else if (i_op == sde_pkg::OP_PUSH_FRONT) begin
                                o_cmd.act = sde_pkg::A_PUSH_FRONT;
                            end else begin
                                o_cmd.act = sde_pkg::A_PUSH_BACK;
                            end
                        end
                        sde_pkg::OP_POP_FRONT, sde_pkg::OP_POP_BACK: begin
                            if (i_sts.empty) begin
                                o_cmd.act    = sde_pkg::A_REPORT;
                                o_cmd.status = sde_pkg::ST_EMPTY;
                            end else if (i_op == sde_pkg::OP_POP_FRONT) begin
                                o_cmd.act = sde_pkg::A_POP_FRONT;
                            end else begin
                                o_cmd.act = sde_pkg::A_POP_BACK;
                            end
                        end
                        sde_pkg::OP_SORT: begin
                            o_cmd.act = i_sts.few_entries ? sde_pkg::A_REPORT
                                                          : sde_pkg::A_SORT_INIT;
                        end
                        sde_pkg::OP_DEDUP: begin
                            o_cmd.act = i_sts.few_entries ? sde_pkg::A_REPORT
                                                          : sde_pkg::A_DD_INIT;
                        end
                        default: o_cmd.act = sde_pkg::A_REPORT;
                    endcase
                end
            end
            sde_pkg::S_POP:        o_cmd.act = sde_pkg::A_POP_DONE;
            sde_pkg::S_SORT_PRIME: o_cmd.act = sde_pkg::A_SORT_PRIME;
            sde_pkg::S_SORT_LOAD:  o_cmd.act = sde_pkg::A_SORT_LOAD;
            sde_pkg::S_SORT_STEP:  o_cmd.act = sde_pkg::A_SORT_STEP;
            sde_pkg::S_SORT_LAST:  o_cmd.act = sde_pkg::A_SORT_LAST;
            sde_pkg::S_FINISH:     o_cmd.act = sde_pkg::A_REPORT;
            sde_pkg::S_DD_CRD:     o_cmd.act = sde_pkg::A_DD_CRD;
            sde_pkg::S_DD_CLD:     o_cmd.act = sde_pkg::A_DD_CLD;
            sde_pkg::S_DD_SCAN:    o_cmd.act = sde_pkg::A_DD_SCAN;
            sde_pkg::S_DD_DONE:    o_cmd.act = sde_pkg::A_DD_DONE;
            default:               o_cmd.act = sde_pkg::A_NOP;
        endcase
    end

    // A result is loaded only when the output register is empty or draining.
    assign w_load = o_cmd.act inside {sde_pkg::A_PUSH_FRONT, sde_pkg::A_PUSH_BACK,
                                      sde_pkg::A_POP_DONE, sde_pkg::A_REPORT,
                                      sde_pkg::A_DD_DONE};

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sde_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/sde_datapath.sv =====
// Datapath of the deque engine: entry RAM, ring pointers, sort and dedup
// counters and the result register. Depends on sde_pkg and sde_ram.
module sde_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  sde_pkg::t_dp_cmd                     i_cmd,
    input  logic signed [sde_pkg::VALUE_W-1:0]   i_value,
    output sde_pkg::t_dp_sts                     o_sts,
    output logic [sde_pkg::STATUS_W-1:0]         o_status,
    output logic [sde_pkg::OUT_COUNT_W-1:0]      o_count,
    output logic signed [sde_pkg::VALUE_W-1:0]   o_removed_value
);

    localparam int IW = sde_pkg::IDX_W;
    localparam int CW = sde_pkg::CNT_W;
    localparam int DW = sde_pkg::DATA_WIDTH;

    logic [IW-1:0] r_front;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_k, r_lim, r_i, r_j, r_kept;
    logic [DW-1:0] r_carry, r_cand;

    logic [sde_pkg::STATUS_W-1:0]       r_status;
    logic [sde_pkg::OUT_COUNT_W-1:0]    r_res_count;
    logic signed [sde_pkg::VALUE_W-1:0] r_removed;

    logic          w_we;
    logic [IW-1:0] w_waddr, w_raddr;
    logic [DW-1:0] w_wdata, w_rdata, w_word;
    logic [IW-1:0] w_front_dec;
    logic [CW-1:0] w_cnt_inc, w_cnt_dec, w_k_inc, w_k_dec, w_j_inc, w_i_inc, w_kept_inc;
    logic          w_carry_gt;

    sde_ram #(
        .WIDTH (DW),
        .DEPTH (sde_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_word      = DW'(i_value);
    assign w_front_dec = (r_front == '0) ? IW'(sde_pkg::CAPACITY - 1) : r_front - 1'b1;
    assign w_cnt_inc   = r_count + 1'b1;
    assign w_cnt_dec   = r_count - 1'b1;
    assign w_k_inc     = r_k + 1'b1;
    assign w_k_dec     = r_k - 1'b1;
    assign w_j_inc     = r_j + 1'b1;
    assign w_i_inc     = r_i + 1'b1;
    assign w_kept_inc  = r_kept + 1'b1;
    assign w_carry_gt  = $signed(r_carry) > $signed(w_rdata);

    assign o_sts.full        = (r_count == CW'(sde_pkg::CAPACITY));
    assign o_sts.empty       = (r_count == '0);
    assign o_sts.few_entries = (r_count < CW'(2));
    assign o_sts.k_at_lim    = (r_k == r_lim);
    assign o_sts.lim_one     = (r_lim == CW'(1));
    assign o_sts.is_match    = (w_rdata == r_cand);
    assign o_sts.j_last      = (w_j_inc == r_kept);
    assign o_sts.i_last      = (w_i_inc == r_count);

    // Memory addressing for each command.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_front;
        w_wdata = r_carry;
        w_raddr = r_front;
        case (i_cmd.act)
            sde_pkg::A_PUSH_FRONT: begin
                w_we    = 1'b1;
                w_waddr = w_front_dec;
                w_wdata = w_word;
            end
            sde_pkg::A_PUSH_BACK: begin
                w_we    = 1'b1;
                w_waddr = sde_pkg::ring_pos(r_front, r_count[IW-1:0]);
                w_wdata = w_word;
            end
            sde_pkg::A_POP_BACK:  w_raddr = sde_pkg::ring_pos(r_front, w_cnt_dec[IW-1:0]);
            sde_pkg::A_SORT_LOAD: w_raddr = sde_pkg::ring_pos(r_front, r_k[IW-1:0]);
            sde_pkg::A_SORT_STEP: begin
                // The smaller of carry and the fetched word settles one slot back.
                w_we    = 1'b1;
                w_waddr = sde_pkg::ring_pos(r_front, w_k_dec[IW-1:0]);
                w_wdata = w_carry_gt ? w_rdata : r_carry;
                w_raddr = sde_pkg::ring_pos(r_front, w_k_inc[IW-1:0]);
            end
            sde_pkg::A_SORT_LAST: begin
                w_we    = 1'b1;
                w_waddr = sde_pkg::ring_pos(r_front, r_lim[IW-1:0]);
                w_wdata = r_carry;
            end
            sde_pkg::A_DD_INIT: w_raddr = sde_pkg::ring_pos(r_front, IW'(1));
            sde_pkg::A_DD_CRD:  w_raddr = sde_pkg::ring_pos(r_front, r_i[IW-1:0]);
            sde_pkg::A_DD_SCAN: begin
                if (!o_sts.is_match && o_sts.j_last) begin
                    w_we    = 1'b1;
                    w_waddr = sde_pkg::ring_pos(r_front, r_kept[IW-1:0]);
                    w_wdata = r_cand;
                end else begin
                    w_raddr = sde_pkg::ring_pos(r_front, w_j_inc[IW-1:0]);
                end
            end
            default: w_we = 1'b0;
        endcase
    end

    // Control state: ring pointers and entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else begin
            case (i_cmd.act)
                sde_pkg::A_PUSH_FRONT: begin
                    r_front <= w_front_dec;
                    r_count <= w_cnt_inc;
                end
                sde_pkg::A_PUSH_BACK: r_count <= w_cnt_inc;
                sde_pkg::A_POP_FRONT: begin
                    r_front <= sde_pkg::ring_pos(r_front, IW'(1));
                    r_count <= w_cnt_dec;
                end
                sde_pkg::A_POP_BACK: r_count <= w_cnt_dec;
                sde_pkg::A_DD_DONE:  r_count <= r_kept;
                default:             r_count <= r_count;
            endcase
        end
    end

    // Working registers of the sort and dedup walks, and the result register.
    always_ff @(posedge i_clk) begin
        case (i_cmd.act)
            sde_pkg::A_PUSH_FRONT, sde_pkg::A_PUSH_BACK: begin
                r_status    <= sde_pkg::ST_OK;
                r_res_count <= sde_pkg::OUT_COUNT_W'(w_cnt_inc);
                r_removed   <= '0;
            end
            sde_pkg::A_POP_DONE: begin
                r_status    <= sde_pkg::ST_OK;
                r_res_count <= sde_pkg::OUT_COUNT_W'(r_count);
                r_removed   <= sde_pkg::VALUE_W'($signed(w_rdata));
            end
            sde_pkg::A_REPORT: begin
                r_status    <= i_cmd.status;
                r_res_count <= sde_pkg::OUT_COUNT_W'(r_count);
                r_removed   <= '0;
            end
            sde_pkg::A_DD_DONE: begin
                r_status    <= sde_pkg::ST_OK;
                r_res_count <= sde_pkg::OUT_COUNT_W'(r_kept);
                r_removed   <= '0;
            end
            sde_pkg::A_SORT_INIT: begin
                r_lim <= w_cnt_dec;
                r_k   <= CW'(1);
            end
            sde_pkg::A_SORT_PRIME: r_k <= CW'(1);
            sde_pkg::A_SORT_LOAD:  r_carry <= w_rdata;
            sde_pkg::A_SORT_STEP: begin
                r_carry <= w_carry_gt ? r_carry : w_rdata;
                r_k     <= w_k_inc;
            end
            sde_pkg::A_SORT_LAST: r_lim <= r_lim - 1'b1;
            sde_pkg::A_DD_INIT: begin
                r_i    <= CW'(1);
                r_kept <= CW'(1);
            end
            sde_pkg::A_DD_CLD: begin
                r_cand <= w_rdata;
                r_j    <= '0;
            end
            sde_pkg::A_DD_SCAN: begin
                if (o_sts.is_match || o_sts.j_last) begin
                    r_i <= w_i_inc;
                    if (!o_sts.is_match) begin
                        r_kept <= w_kept_inc;
                    end
                end else begin
                    r_j <= w_j_inc;
                end
            end
            default: r_carry <= r_carry;
        endcase
    end

    assign o_status        = r_status;
    assign o_count         = r_res_count;
    assign o_removed_value = r_removed;

endmodule

// ===== rtl/sorting_deque_engine.sv =====
// Top level of the sorting deque engine: controller, datapath and assertions.
// Depends on sde_pkg, sde_in_if, sde_out_if, sde_ctrl, sde_datapath and the macro header.
//
//   Channel   Dir   Beat contents
//   i_cmd     in    op (3b), value (32b signed)
//   o_rsp     out   status (2b), count (5b), removed_value (32b signed)
//
// Push, error and no-op beats load the result register on acceptance; pops first pass through
// S_POP for the registered RAM read. Sort with n entries runs bubble passes through the
// single-read-port entry RAM; dedup runs compare scans of each entry against those kept.
// Reset clears the ring pointers, count, controller state and output valid only; the entry RAM needs no clearing.
// A result held in the output register while o_rsp.ready is low keeps i_cmd.ready low.
`include "sorting_deque_engine_macros.svh"

module sorting_deque_engine (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sde_in_if.sink    i_cmd,
    sde_out_if.source o_rsp
);

    sde_pkg::t_dp_cmd w_cmd;
    sde_pkg::t_dp_sts w_sts;
    logic             w_push_beat;
    logic             w_err_beat;

    sde_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .i_op        (i_cmd.op),
        .i_out_ready (o_rsp.ready),
        .i_sts       (w_sts),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (w_cmd)
    );

    sde_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_value         (i_cmd.value),
        .o_sts           (w_sts),
        .o_status        (o_rsp.status),
        .o_count         (o_rsp.count),
        .o_removed_value (o_rsp.removed_value)
    );

    assign w_push_beat = i_cmd.valid && i_cmd.ready &&
                         (i_cmd.op inside {sde_pkg::OP_PUSH_FRONT, sde_pkg::OP_PUSH_BACK});
    assign w_err_beat  = o_rsp.valid && (o_rsp.status != sde_pkg::ST_OK);

    `SDE_ASSERT_SAME(a_stall_blocks_input, o_rsp.valid && !o_rsp.ready, !i_cmd.ready)
    `SDE_ASSERT_SAME(a_count_bounded, o_rsp.valid, o_rsp.count <= sde_pkg::CAPACITY)
    `SDE_ASSERT_SAME(a_error_no_word, w_err_beat, o_rsp.removed_value == '0)
    `SDE_ASSERT_NEXT(a_push_one_cycle, w_push_beat, o_rsp.valid)

endmodule
